// ===== hdl/jab_pkg.sv =====
// ----------------------------------------------------------------------------
// jab_pkg
// Shared types and constants of the joystick axis to buttons block.
// ----------------------------------------------------------------------------
package jab_pkg;

  // Fixed field widths.
  localparam int SAMPLE_BITS = 12;
  localparam int CH_BITS     = 3;
  localparam int SENS_BITS   = 8;
  localparam int PROD_BITS   = SAMPLE_BITS + SENS_BITS;

  // Sensitivity in Q1.7; one is the full scale.
  localparam logic [SENS_BITS-1:0] SENS_ONE        = 8'd128;
  localparam logic [SENS_BITS-1:0] SENS_RESET_BYTE = 8'h80;

  // Calibration and reset levels in millivolts.
  localparam logic [SAMPLE_BITS-1:0] CAL_SPAN     = 12'd200;
  localparam logic [SAMPLE_BITS-1:0] CAL_MAX      = 12'd3300;
  localparam logic [SAMPLE_BITS-1:0] RESET_CENTER = 12'd2000;
  localparam logic [SAMPLE_BITS-1:0] RESET_LOW    = 12'd1800;
  localparam logic [SAMPLE_BITS-1:0] RESET_HIGH   = 12'd2200;

  // Item modes.
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_CAL    = 1'b1;

  // Button sides.
  localparam logic SIDE_LOW  = 1'b0;
  localparam logic SIDE_HIGH = 1'b1;

  // Queue depths.
  localparam int CMDQ_DEPTH = 2;
  localparam int EVQ_DEPTH  = 4;

  // One input item.
  typedef struct packed {
    logic                   mode;
    logic [CH_BITS-1:0]     channel;
    logic [SAMPLE_BITS-1:0] voltage_mv;
  } jab_in_t;

  // One result item.
  typedef struct packed {
    logic [CH_BITS-1:0] channel_res;
    logic               side;
    logic               new_pressed;
    logic               old_pressed;
    logic               last;
  } jab_out_t;

  // A classified item handed from the front to the back.
  typedef struct packed {
    jab_in_t              item;
    logic [SENS_BITS-1:0] sens;
  } jab_cmd_t;

  // Up to two events written into the event queue in one cycle.
  typedef struct packed {
    logic     v0;
    jab_out_t e0;
    logic     v1;
    jab_out_t e1;
  } jab_evt_push_t;

endpackage

// ===== hdl/jab_front.sv =====
// ----------------------------------------------------------------------------
// jab_front
// Accepts input items, drops those for absent channels and attaches the
// saturated sensitivity of the channel. Holds the sensitivity register.
// ----------------------------------------------------------------------------
module jab_front import jab_pkg::*; #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  jab_in_t                       in_data,
  output logic                          full,
  input  logic                          cfg_valid,
  input  logic [SENS_BITS*8-1:0]        cfg_data,
  output logic                          cfg_ready,
  input  logic                          q_full,
  output logic                          cmd_push,
  output jab_cmd_t                      cmd_data
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [SENS_BITS-1:0] sens_r [NUM_CHANNELS];
  logic [CH_BITS:0]     ch_ext;
  logic                 present;
  logic [SENS_BITS-1:0] sens_raw;

  // Sensitivity register, one byte per channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sens_r[i] <= SENS_RESET_BYTE;
      end
    end else if (cfg_valid) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sens_r[i] <= cfg_data[i*SENS_BITS +: SENS_BITS];
      end
    end
  end

  assign cfg_ready = 1'b1;

  // Classify: channels beyond the configured count are accepted and dropped.
  assign ch_ext   = {1'b0, in_data.channel};
  assign present  = ch_ext < (CH_BITS+1)'(NUM_CHANNELS);
  assign sens_raw = sens_r[in_data.channel[IDX_W-1:0]];

  always_comb begin
    cmd_data.item = in_data;
    cmd_data.sens = (sens_raw > SENS_ONE) ? SENS_ONE : sens_raw;
  end

  assign full     = q_full;
  assign cmd_push = push && !q_full && present;

endmodule

// ===== hdl/jab_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// jab_cmd_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module jab_cmd_queue import jab_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  jab_cmd_t wr_data,
  output logic     q_full,
  input  logic     rd_en,
  output logic     rd_valid,
  output jab_cmd_t rd_data
);

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  jab_cmd_t             mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0]     wptr_r;
  logic [PTR_W-1:0]     rptr_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     cnt_nxt;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr_en) begin
        wptr_r <= (wptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
      end
      if (rd_en) begin
        rptr_r <= (rptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign q_full   = cnt_r == CNT_W'(CMDQ_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rptr_r];

endmodule

// ===== hdl/jab_back.sv =====
// ----------------------------------------------------------------------------
// jab_back
// Carries out items: per-channel range tracking, threshold arithmetic and
// button state, in two stages. Produces up to two change events per item.
// ----------------------------------------------------------------------------
module jab_back import jab_pkg::*; #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  jab_cmd_t      cmd_data,
  output logic          cmd_pop,
  input  logic          evt_room,
  output jab_evt_push_t evt_push
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Per-channel state.
  logic [SAMPLE_BITS-1:0] lo_r [NUM_CHANNELS];
  logic [SAMPLE_BITS-1:0] ce_r [NUM_CHANNELS];
  logic [SAMPLE_BITS-1:0] hi_r [NUM_CHANNELS];
  logic                   lp_r [NUM_CHANNELS];
  logic                   hp_r [NUM_CHANNELS];

  // Stage two registers.
  logic                   s2_valid_r;
  logic [CH_BITS-1:0]     s2_ch_r;
  logic [SAMPLE_BITS-1:0] s2_v_r;
  logic [SAMPLE_BITS-1:0] s2_ce_r;
  logic [SAMPLE_BITS-1:0] s2_hi_r;
  logic                   s2_dneg_r;
  logic [PROD_BITS-1:0]   s2_pl_r;
  logic [PROD_BITS-1:0]   s2_ph_r;

  // Stage one signals.
  logic                   s1_go;
  logic                   s2_commit;
  logic [IDX_W-1:0]       s1_idx;
  logic [SAMPLE_BITS-1:0] v1;
  logic [SAMPLE_BITS-1:0] lo_cur;
  logic [SAMPLE_BITS-1:0] ce_cur;
  logic [SAMPLE_BITS-1:0] hi_cur;
  logic [SAMPLE_BITS-1:0] lo_n;
  logic [SAMPLE_BITS-1:0] hi_n;
  logic [SAMPLE_BITS:0]   lsum;
  logic [SAMPLE_BITS:0]   hsum;
  logic [SAMPLE_BITS-1:0] ht0;
  logic signed [SAMPLE_BITS:0] dlt;
  logic [SAMPLE_BITS:0]   dmag;
  logic [PROD_BITS-1:0]   pl;
  logic [PROD_BITS-1:0]   ph;
  logic [SAMPLE_BITS-1:0] cal_lo;
  logic [SAMPLE_BITS-1:0] cal_hi;
  logic [SAMPLE_BITS:0]   cal_hi_w;
  logic [SAMPLE_BITS-1:0] cal_lo_w;

  // Stage two signals.
  logic [IDX_W-1:0]       s2_idx;
  logic [SAMPLE_BITS-1:0] lt;
  logic [SAMPLE_BITS-1:0] pmag;
  logic [SAMPLE_BITS:0]   ht_w;
  logic [SAMPLE_BITS-1:0] ht;
  logic [SAMPLE_BITS:0]   lr_sum;
  logic [SAMPLE_BITS:0]   hr_sum;
  logic [SAMPLE_BITS-1:0] lr;
  logic [SAMPLE_BITS-1:0] hr;
  logic                   old_lo;
  logic                   old_hi;
  logic                   nl;
  logic                   nh;
  logic                   ch_lo;
  logic                   ch_hi;

  // Handshake between the stages.
  assign s2_commit = s2_valid_r && evt_room;
  assign s1_go     = cmd_valid && (!s2_valid_r || s2_commit);
  assign cmd_pop   = s1_go;

  // Stage one: range update, threshold midpoints and the two products.
  assign s1_idx = cmd_data.item.channel[IDX_W-1:0];
  assign v1     = cmd_data.item.voltage_mv;
  assign lo_cur = lo_r[s1_idx];
  assign ce_cur = ce_r[s1_idx];
  assign hi_cur = hi_r[s1_idx];

  always_comb begin
    lo_n = (v1 < lo_cur) ? v1 : lo_cur;
    hi_n = (v1 > hi_cur) ? v1 : hi_cur;
    lsum = {1'b0, lo_n} + {1'b0, ce_cur};
    hsum = {1'b0, ce_cur} + {1'b0, hi_n};
    ht0  = hsum[SAMPLE_BITS:1];
    dlt  = $signed({1'b0, hi_n}) - $signed({1'b0, ht0});
    dmag = dlt[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-dlt) : (SAMPLE_BITS+1)'(dlt);
    pl   = {{SENS_BITS{1'b0}}, lsum[SAMPLE_BITS:1]} *
           {{SAMPLE_BITS{1'b0}}, cmd_data.sens};
    ph   = {{SENS_BITS{1'b0}}, dmag[SAMPLE_BITS-1:0]} *
           {{SAMPLE_BITS{1'b0}}, cmd_data.sens};
  end

  // Calibration levels, clamped to the calibration window.
  always_comb begin
    cal_lo_w = (v1 < CAL_SPAN) ? '0 : v1 - CAL_SPAN;
    cal_lo   = (cal_lo_w > CAL_MAX) ? CAL_MAX : cal_lo_w;
    cal_hi_w = {1'b0, v1} + {1'b0, CAL_SPAN};
    cal_hi   = (cal_hi_w > {1'b0, CAL_MAX}) ? CAL_MAX : cal_hi_w[SAMPLE_BITS-1:0];
  end

  // Range state is written as the item leaves stage one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        lo_r[i] <= RESET_LOW;
        ce_r[i] <= RESET_CENTER;
        hi_r[i] <= RESET_HIGH;
      end
    end else if (s1_go) begin
      if (cmd_data.item.mode == MODE_CAL) begin
        ce_r[s1_idx] <= v1;
        lo_r[s1_idx] <= cal_lo;
        hi_r[s1_idx] <= cal_hi;
      end else begin
        lo_r[s1_idx] <= lo_n;
        hi_r[s1_idx] <= hi_n;
      end
    end
  end

  // Stage two control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_go) begin
      s2_valid_r <= cmd_data.item.mode == MODE_UPDATE;
    end else if (s2_commit) begin
      s2_valid_r <= 1'b0;
    end
  end

  // Stage two payload.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_ch_r   <= cmd_data.item.channel;
      s2_v_r    <= v1;
      s2_ce_r   <= ce_cur;
      s2_hi_r   <= hi_n;
      s2_dneg_r <= dlt[SAMPLE_BITS];
      s2_pl_r   <= pl;
      s2_ph_r   <= ph;
    end
  end

  // Stage two: thresholds, press and release decisions.
  assign s2_idx = s2_ch_r[IDX_W-1:0];
  assign old_lo = lp_r[s2_idx];
  assign old_hi = hp_r[s2_idx];

  always_comb begin
    lt     = s2_pl_r[PROD_BITS-2:SENS_BITS-1];
    pmag   = s2_ph_r[PROD_BITS-2:SENS_BITS-1];
    ht_w   = s2_dneg_r ? ({1'b0, s2_hi_r} + {1'b0, pmag})
                       : ({1'b0, s2_hi_r} - {1'b0, pmag});
    ht     = ht_w[SAMPLE_BITS-1:0];
    lr_sum = {1'b0, lt} + {1'b0, s2_ce_r};
    hr_sum = {1'b0, s2_ce_r} + {1'b0, ht};
    lr     = lr_sum[SAMPLE_BITS:1];
    hr     = hr_sum[SAMPLE_BITS:1];
    nl     = old_lo;
    nh     = old_hi;
    if (s2_v_r == '0 || s2_v_r < lt) begin
      nl = 1'b1;
    end
    if (s2_v_r > ht) begin
      nh = 1'b1;
    end
    if (s2_v_r > lr && s2_v_r < hr) begin
      nl = 1'b0;
      nh = 1'b0;
    end
    ch_lo = nl != old_lo;
    ch_hi = nh != old_hi;
  end

  // Button state is written when stage two hands its events over.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        lp_r[i] <= 1'b0;
        hp_r[i] <= 1'b0;
      end
    end else if (s2_commit) begin
      lp_r[s2_idx] <= nl;
      hp_r[s2_idx] <= nh;
    end
  end

  // Change events, low side first.
  always_comb begin
    evt_push.v0             = s2_commit && ch_lo;
    evt_push.e0.channel_res = s2_ch_r;
    evt_push.e0.side        = SIDE_LOW;
    evt_push.e0.new_pressed = nl;
    evt_push.e0.old_pressed = old_lo;
    evt_push.e0.last        = !ch_hi;
    evt_push.v1             = s2_commit && ch_hi;
    evt_push.e1.channel_res = s2_ch_r;
    evt_push.e1.side        = SIDE_HIGH;
    evt_push.e1.new_pressed = nh;
    evt_push.e1.old_pressed = old_hi;
    evt_push.e1.last        = 1'b1;
  end

endmodule

// ===== hdl/jab_evt_queue.sv =====
// ----------------------------------------------------------------------------
// jab_evt_queue
// Result queue: takes up to two events per cycle, hands out one.
// ----------------------------------------------------------------------------
module jab_evt_queue import jab_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  jab_evt_push_t evt_push,
  output logic          evt_room,
  input  logic          pop,
  output logic          empty,
  output jab_out_t      out_data
);

  localparam int PTR_W = $clog2(EVQ_DEPTH);
  localparam int CNT_W = $clog2(EVQ_DEPTH + 1);

  jab_out_t         mem_r [EVQ_DEPTH];
  logic [PTR_W-1:0] head_r;
  logic [PTR_W-1:0] tail_r;
  logic [PTR_W-1:0] tail_p1;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] n_in;
  logic             do_pop;

  assign tail_p1 = tail_r + PTR_W'(1);
  assign n_in    = CNT_W'(evt_push.v0) + CNT_W'(evt_push.v1);
  assign do_pop  = pop && !empty;

  // Compacted writes: the first valid event lands at the tail.
  always_ff @(posedge clk) begin
    if (evt_push.v0) begin
      mem_r[tail_r] <= evt_push.e0;
      if (evt_push.v1) begin
        mem_r[tail_p1] <= evt_push.e1;
      end
    end else if (evt_push.v1) begin
      mem_r[tail_r] <= evt_push.e1;
    end
  end

  assign cnt_nxt = cnt_r + n_in - CNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      tail_r <= tail_r + PTR_W'(n_in);
      if (do_pop) begin
        head_r <= head_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign evt_room = cnt_r <= CNT_W'(EVQ_DEPTH - 2);
  assign empty    = cnt_r == '0;
  assign out_data = mem_r[head_r];

endmodule

// ===== hdl/joystick_axis_to_buttons.sv =====
// ----------------------------------------------------------------------------
// joystick_axis_to_buttons
// Turns per-channel joystick axis samples into low and high button events.
// ----------------------------------------------------------------------------
// Path: a change event reaches the result ports after its sample passes the
// command queue, the products stage, the decision stage and the result queue.
// Throughput: one sample per cycle into the decision pipeline while the result
// queue has room; the result port moves one event per cycle.
// Reset (synchronous, active low): queues empty, levels 1800/2000/2200 mV,
// buttons released, every channel sensitivity at 1.0.
module joystick_axis_to_buttons import jab_pkg::*; #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  jab_in_t                in_data,
  output logic                   full,
  output logic                   empty,
  input  logic                   pop,
  output jab_out_t               out_data,
  input  logic                   cfg_valid,
  input  logic [SENS_BITS*8-1:0] cfg_data,
  output logic                   cfg_ready
);

  logic          q_full;
  logic          cmd_push;
  jab_cmd_t      cmd_in;
  logic          cmd_valid;
  logic          cmd_pop;
  jab_cmd_t      cmd_out;
  logic          evt_room;
  jab_evt_push_t evt_push;

  // Front: accept and classify.
  jab_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .q_full    (q_full),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in)
  );

  // Queue between front and back.
  jab_cmd_queue u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cmd_push),
    .wr_data  (cmd_in),
    .q_full   (q_full),
    .rd_en    (cmd_pop),
    .rd_valid (cmd_valid),
    .rd_data  (cmd_out)
  );

  // Back: levels, thresholds and button state.
  jab_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .evt_room  (evt_room),
    .evt_push  (evt_push)
  );

  // Result queue.
  jab_evt_queue u_evtq (
    .clk      (clk),
    .rst_n    (rst_n),
    .evt_push (evt_push),
    .evt_room (evt_room),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

// ===== hdl/jab_checker.sv =====
// ----------------------------------------------------------------------------
// jab_checker
// Port-level checks of the joystick axis to buttons block, bound to the top.
// ----------------------------------------------------------------------------
module jab_checker import jab_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     empty,
  input logic     pop,
  input jab_out_t out_data
);

  // The result queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // Every event reports a real change of button state.
  a_real_change: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_data.new_pressed != out_data.old_pressed)
    else $error("event without a state change");

  // Only a low-side event can be followed by another event of the same sample.
  a_last_side: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.last) |-> out_data.side == SIDE_LOW)
    else $error("high-side event not marked last");

  // A waiting result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed");

endmodule

bind joystick_axis_to_buttons jab_checker u_jab_checker (.*);
